// ===== rtl/rse_pkg.sv =====
// Package for the GF(256) Reed-Solomon encoder: field arithmetic, generator
// coefficients and the cell control struct.
// No dependencies.
`default_nettype none

package rse_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned PARITY_LEN  = 16;
  localparam int unsigned MAX_DATA    = 239;
  localparam int unsigned MAX_PARITY  = 32;
  localparam logic [8:0]  GF_POLY     = 9'h11D;

  // control for every cell of the parity chain
  typedef struct packed {
    logic shift;  // take neighbor ^ fb*coef
    logic clear;  // drop to zero
  } cell_ctrl_t;

  // GF(256) product, shift-and-add over the 8 bits of b
  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b);
    logic [8:0]       aa;
    logic [SYM_W-1:0] acc;
    aa  = {1'b0, a};
    acc = '0;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) begin
        acc = acc ^ aa[SYM_W-1:0];
      end
      aa = {aa[SYM_W-1:0], 1'b0};
      if (aa[8]) begin
        aa = aa ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  // coefficient of x^idx in g(x) = prod (x - a^i), i = 0..n-1; elaboration only
  function automatic logic [SYM_W-1:0] gen_coef(input int unsigned n,
                                                input int unsigned idx);
    logic [SYM_W-1:0] g [MAX_PARITY+1];
    logic [SYM_W-1:0] root;
    for (int j = 0; j <= MAX_PARITY; j++) begin
      g[j] = '0;
    end
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j > 0; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
      root = gf_mul(root, 8'h02);
    end
    return g[idx];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rse_cell.sv =====
// One tap of the parity shift register: holds one remainder byte.
// Depends on rse_pkg.
`default_nettype none

module rse_cell #(
  parameter logic [rse_pkg::SYM_W-1:0] COEF = 8'h01
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire rse_pkg::cell_ctrl_t    ctrl_i,
  input  wire [rse_pkg::SYM_W-1:0]    prev_i,  // lower neighbor, zero for tap 0
  input  wire [rse_pkg::SYM_W-1:0]    fb_i,    // feedback byte, zero while draining
  output logic [rse_pkg::SYM_W-1:0]   q_o
);

  logic [rse_pkg::SYM_W-1:0] tap_q, tap_d;

  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.clear) begin
      tap_d = '0;
    end else if (ctrl_i.shift) begin
      tap_d = prev_i ^ rse_pkg::gf_mul(fb_i, COEF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign q_o = tap_q;

endmodule

`default_nettype wire

// ===== rtl/reed_solomon_systematic_encoder_unit.sv =====
// Top level of the systematic Reed-Solomon encoder over GF(256), poly 0x11D.
// Depends on rse_pkg and rse_cell.
//
// Usage:
//   Input stream (s_axis_*): one message byte per transfer in tdata, tlast on
//   the final byte of the message. Output stream (m_axis_*): every data byte
//   comes back unchanged, then PARITY_LEN parity bytes, highest degree first.
//   tuser[0] flags a parity byte, tuser[1] flags a message byte past the first
//   MAX_DATA bytes, tlast marks the final byte of the codeword.
//   Parity is the remainder of m(x)*x^PARITY_LEN by g(x) = prod (x - a^i).
//   It is formed in a row of PARITY_LEN cells, one remainder byte each; all
//   taps update together, so a data byte is taken every cycle unless held off.
//   The output byte is registered and appears in the cycle after its input.
//   Throughput: one data byte per cycle unless the receiver stalls. After the
//   last byte of a message the cells shift their contents out, one
//   byte per cycle unless the receiver stalls, while the input is held off.
//   An overlong message gets no parity; bytes past MAX_DATA pass through with
//   the too-long flag and skip the cells. Reset clears the cells, the byte
//   count and the overflow flag; the block is ready at once. A receiver stall
//   holds the output register and, with it, the input side and the parity
//   drain; nothing is dropped.
`default_nettype none

module reed_solomon_systematic_encoder_unit #(
  parameter int unsigned PARITY_LEN = rse_pkg::PARITY_LEN,  // 2..32
  parameter int unsigned MAX_DATA   = rse_pkg::MAX_DATA     // 1..253
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire         s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser_o,   // [0] is_parity, [1] too_long
  output logic        m_axis_tlast_o    // block_end
);

  localparam int unsigned SYM_W   = rse_pkg::SYM_W;
  localparam int unsigned CNT_W   = rse_pkg::CNT_W;
  localparam int unsigned DRAIN_W = $clog2(PARITY_LEN + 1);

  // message state
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [DRAIN_W-1:0] drain_q, drain_d;   // parity bytes still to send

  // output register
  logic               out_vld_q, out_vld_d;
  logic [SYM_W-1:0]   out_byte_q, out_byte_d;
  logic               out_par_q, out_par_d;
  logic               out_end_q, out_end_d;
  logic               out_tl_q, out_tl_d;

  logic               draining, out_free, in_xfer, ovf_now;
  logic [SYM_W-1:0]   fb;
  rse_pkg::cell_ctrl_t ctrl;
  logic [SYM_W-1:0]   tap [PARITY_LEN];

  assign draining = (drain_q != '0);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !draining && out_free;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign ovf_now  = ovf_q || (cnt_q >= CNT_W'(MAX_DATA));

  // feedback is forced to zero while draining: the row then just shifts
  assign fb = draining ? '0 : (s_axis_tdata_i ^ tap[PARITY_LEN-1]);

  always_comb begin
    ctrl.shift = (in_xfer && !ovf_now) || (draining && out_free);
    ctrl.clear = in_xfer && s_axis_tlast_i && ovf_now;
  end

  // parity cells
  for (genvar i = 0; i < PARITY_LEN; i++) begin : g_cell
    logic [SYM_W-1:0] prev;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_next
      assign prev = tap[i-1];
    end
    rse_cell #(
      .COEF(rse_pkg::gen_coef(PARITY_LEN, i))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .prev_i(prev),
      .fb_i  (fb),
      .q_o   (tap[i])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    drain_d    = drain_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_byte_d = out_byte_q;
    out_par_d  = out_par_q;
    out_end_d  = out_end_q;
    out_tl_d   = out_tl_q;
    if (in_xfer) begin
      out_vld_d  = 1'b1;
      out_byte_d = s_axis_tdata_i;
      out_par_d  = 1'b0;
      out_end_d  = s_axis_tlast_i && ovf_now;
      out_tl_d   = ovf_now;
      if (s_axis_tlast_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
        if (!ovf_now) begin
          drain_d = DRAIN_W'(PARITY_LEN);
        end
      end else if (ovf_now) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (draining && out_free) begin
      out_vld_d  = 1'b1;
      out_byte_d = tap[PARITY_LEN-1];
      out_par_d  = 1'b1;
      out_end_d  = (drain_q == DRAIN_W'(1));
      out_tl_d   = 1'b0;
      drain_d    = drain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      drain_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_par_q  <= out_par_d;
    out_end_q  <= out_end_d;
    out_tl_q   <= out_tl_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = {out_tl_q, out_par_q};
  assign m_axis_tlast_o  = out_end_q;

  // any tap still holding a nonzero byte
  logic taps_nz;
  always_comb begin
    taps_nz = 1'b0;
    for (int i = 0; i < PARITY_LEN; i++) begin
      taps_nz = taps_nz | (tap[i] != '0);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DATA))
    else $error("byte count past MAX_DATA");

  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i && !ovf_now) |=>
      (drain_q == DRAIN_W'(PARITY_LEN)) && out_vld_q && !out_end_q && !out_par_q)
    else $error("parity drain did not start after last byte");

  a_taps_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(draining) && !draining) |-> !taps_nz && (cnt_q == '0))
    else $error("parity taps not clear after drain");

  a_overlong_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i && ovf_now) |=>
      !draining && !taps_nz && out_end_q && out_tl_q)
    else $error("overlong message not closed");

endmodule

`default_nettype wire

// ===== tb/sv/rse_codeword_checker.sv =====
// Codeword checker for the Reed-Solomon encoder: predicts every output byte
// from the input transfers and compares it with the output transfers.
// Depends on rse_pkg for the field polynomial and the default sizes.

module rse_codeword_checker #(
  parameter int unsigned PARITY_LEN = rse_pkg::PARITY_LEN,
  parameter int unsigned MAX_DATA   = rse_pkg::MAX_DATA
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,
  input  logic [1:0] m_axis_tuser_i,
  input  logic       m_axis_tlast_i,
  output int         mismatches_o,
  output int         outstanding_o
);

  typedef struct packed {
    logic [7:0] sym;
    logic       is_parity;
    logic       block_end;
    logic       too_long;
  } code_sym_t;

  logic [7:0]  antilog [0:254];
  int unsigned field_log [0:255];
  logic [7:0]  gen_poly [0:PARITY_LEN];
  logic [7:0]  remainder [0:PARITY_LEN-1];
  int unsigned msg_len;
  logic        overlong;
  code_sym_t   codeword_q [$];

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    if (a == 8'h00 || b == 8'h00) return 8'h00;
    return antilog[(field_log[a] + field_log[b]) % 255];
  endfunction

  // log tables, then g(x) = prod (x + a^i) built from them
  initial begin : build_tables
    logic [8:0] v;
    logic [7:0] root;
    v = 9'h001;
    for (int e = 0; e < 255; e++) begin
      antilog[e]         = v[7:0];
      field_log[v[7:0]]  = e;
      v = v << 1;
      if (v[8]) v = v ^ rse_pkg::GF_POLY;
    end
    for (int j = 0; j <= PARITY_LEN; j++) gen_poly[j] = 8'h00;
    gen_poly[0] = 8'h01;
    root        = 8'h01;
    for (int i = 0; i < PARITY_LEN; i++) begin
      for (int j = i + 1; j > 0; j--) gen_poly[j] = gen_poly[j-1] ^ gf_prod(gen_poly[j], root);
      gen_poly[0] = gf_prod(gen_poly[0], root);
      root        = gf_prod(root, 8'h02);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      mismatches_o++;
    end
  endtask

  // appends one predicted output byte
  task automatic add_expected(input logic [7:0] sym_v, input logic par_v,
                              input logic end_v, input logic tl_v);
    code_sym_t s;
    s = '{sym_v, par_v, end_v, tl_v};
    codeword_q = {codeword_q, s};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    code_sym_t  got;
    code_sym_t  want;
    logic [7:0] fb;
    if (!rst_ni) begin
      for (int i = 0; i < PARITY_LEN; i++) remainder[i] = 8'h00;
      msg_len       = 0;
      overlong      = 1'b0;
      mismatches_o  = 0;
      outstanding_o = 0;
      codeword_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        // bytes past MAX_DATA skip the division
        if (msg_len >= MAX_DATA) begin
          overlong = 1'b1;
        end else begin
          fb = s_axis_tdata_i ^ remainder[PARITY_LEN-1];
          for (int i = PARITY_LEN - 1; i > 0; i--)
            remainder[i] = remainder[i-1] ^ gf_prod(fb, gen_poly[i]);
          remainder[0] = gf_prod(fb, gen_poly[0]);
          msg_len++;
        end
        if (!s_axis_tlast_i) begin
          add_expected(s_axis_tdata_i, 1'b0, 1'b0, overlong);
        end else if (overlong) begin
          add_expected(s_axis_tdata_i, 1'b0, 1'b1, 1'b1);
        end else begin
          add_expected(s_axis_tdata_i, 1'b0, 1'b0, 1'b0);
          for (int i = PARITY_LEN - 1; i >= 0; i--)
            add_expected(remainder[i], 1'b1, i == 0, 1'b0);
        end
        if (s_axis_tlast_i) begin
          for (int i = 0; i < PARITY_LEN; i++) remainder[i] = 8'h00;
          msg_len  = 0;
          overlong = 1'b0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{m_axis_tdata_i, m_axis_tuser_i[0], m_axis_tlast_i, m_axis_tuser_i[1]};
        if (codeword_q.size() == 0) begin
          $error("unexpected output byte %0h", got.sym);
          mismatches_o++;
        end else begin
          want = codeword_q.pop_front();
          check_field("out_byte", want.sym, got.sym);
          check_field("is_parity", want.is_parity, got.is_parity);
          check_field("block_end", want.block_end, got.block_end);
          check_field("too_long", want.too_long, got.too_long);
        end
      end
      outstanding_o = codeword_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for reed_solomon_systematic_encoder_unit: drives messages with
// random gaps and stalls; rse_codeword_checker does the prediction.
// Depends on rse_pkg, the encoder RTL and rse_codeword_checker.

module tb;

  localparam int unsigned PARITY_LEN  = rse_pkg::PARITY_LEN;
  localparam int unsigned MAX_DATA    = rse_pkg::MAX_DATA;
  // watchdog limit, with a wide margin over the slowest run
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_left = 0;
  logic        calm       = 1'b0;   // stretch with no gaps and no stalls
  logic [7:0]  msg_q [$];           // bytes of the message being sent

  always #5 clk_i = ~clk_i;

  reed_solomon_systematic_encoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] data_byte
    .s_axis_tlast_i  (s_axis_tlast_i),   // last
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] is_parity, [1] too_long
    .m_axis_tlast_o  (m_axis_tlast_o)    // block_end
  );

  rse_codeword_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  // Gap or stall length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stalls; calm stretches come and go so that some
  // messages and parity drains run back to back at full rate.
  always @(posedge clk_i) begin
    int unsigned g;
    if ($urandom_range(0, 149) == 0) calm <= ~calm;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      g = pick_gap();
      if (g != 0) begin
        stall_left      <= g - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("reed_solomon_systematic_encoder_unit: mismatch");
      $finish;
    end
  end

  // Sends msg_q as one message, tlast on the final byte. Each byte waits for
  // its transfer; tvalid stays high across back-to-back bytes.
  task automatic send_msg();
    int unsigned gap;
    while (msg_q.size() != 0) begin
      gap = pick_gap();
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= msg_q[0];
      s_axis_tlast_i  <= (msg_q.size() == 1);
      void'(msg_q.pop_front());
      do @(posedge clk_i); while (!s_axis_tready_o);
    end
  endtask

  initial begin : stimulus
    int unsigned short_sent;
    int unsigned msg_idx;
    int unsigned len;
    short_sent = 0;
    msg_idx    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte messages at both extremes, an all-zero message
    // (zero parity), mixed extremes, and a short two-byte message.
    msg_q = '{8'h00};
    send_msg();
    msg_q = '{8'hFF};
    send_msg();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
    msg_q = '{8'hFF, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55};
    send_msg();
    msg_q = '{8'h01, 8'h02};
    send_msg();

    // Random messages, mostly short. Three long ones hit the length limit:
    // exactly MAX_DATA (full parity), one byte over (only the last byte is
    // overlong), and 2 to 20 bytes over (two or more too-long bytes, no parity).
    while (short_sent < 100 || msg_idx <= 11) begin
      case (msg_idx)
        3:       len = MAX_DATA;
        7:       len = MAX_DATA + 1;
        11:      len = MAX_DATA + $urandom_range(2, 20);
        default: begin
          len        = $urandom_range(1, 12);
          short_sent += len;
        end
      endcase
      for (int i = 0; i < len; i++) msg_q = {msg_q, 8'($urandom_range(0, 255))};
      send_msg();
      msg_idx++;
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: let the checker take the final transfer, wait for every
    // predicted byte, then wait longer so that a stray extra transfer would
    // still be caught.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (PARITY_LEN + 4) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("reed_solomon_systematic_encoder_unit: match");
    end else begin
      $display("reed_solomon_systematic_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule
